// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros : assertion wrappers used by the RTL
// Clocked property checks that reduce to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// check prop on every rising clk edge, suspended while arst_n is low
`define XFP_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("xfp assertion failed");
// check prop on every rising clk edge, reset included
`define XFP_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("xfp assertion failed");
`else
`define XFP_ASSERT(lbl, prop)
`define XFP_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// File: hw/rtl/xfp_pkg.sv
// ----------------------------------------------------------------------------
// xfp_pkg : shared types and constants of the XOR frame parser
// Payload limit, sync bytes, result codes and parser states.
// ----------------------------------------------------------------------------
`default_nettype none

package xfp_pkg;

	localparam int PayloadMax = 32;
	localparam int AddrW      = (PayloadMax > 1) ? $clog2(PayloadMax) : 1;
	localparam int SizeW      = $clog2(PayloadMax + 1);

	localparam logic [7:0] SyncDollar = 8'h24;
	localparam logic [7:0] SyncM      = 8'h4D;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_BAD_HEADER = 2'd1,
		ST_TOO_LARGE  = 2'd2,
		ST_BAD_CRC    = 2'd3
	} status_t;

	typedef enum logic [7:0] {
		PH_WAIT  = 8'b0000_0001,
		PH_M     = 8'b0000_0010,
		PH_DIR   = 8'b0000_0100,
		PH_SIZE  = 8'b0000_1000,
		PH_DATA  = 8'b0001_0000,
		PH_CHECK = 8'b0010_0000,
		PH_RD    = 8'b0100_0000,
		PH_OUT   = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] direction;
		logic [6:0] frame_size;
		logic       byte_valid;
		logic [7:0] data_byte;
		logic [5:0] byte_index;
		logic       last;
	} result_t;

endpackage

`default_nettype wire

// File: hw/rtl/xor_frame_parser.sv
// ----------------------------------------------------------------------------
// xor_frame_parser : '$' 'M' dir size payload check frame receiver
// A header or payload byte is taken on each handshake; an error or empty-frame
// result is registered in the accepting cycle. A good frame drains each payload
// byte by a RAM read, then an output load once the output is free, input held.
// Reset clears parser state and the output valid; the payload RAM is not reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module xor_frame_parser (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  wire         m_tready,
	// [7:0] direction, [14:8] frame_size, [22:15] data_byte,
	// [28:23] byte_index, [31:29] zero
	output logic [31:0] m_tdata,
	output logic [2:0]  m_tuser,   // [1:0] status, [2] byte_valid
	output logic        m_tlast
);

	localparam int SizeW = xfp_pkg::SizeW;
	localparam int AddrW = xfp_pkg::AddrW;

	xfp_pkg::phase_t  state_q, state_d;
	logic [7:0]       dir_q, dir_d;
	logic [SizeW-1:0] size_q, size_d;
	logic [SizeW-1:0] cnt_q, cnt_d;
	logic [7:0]       xor_q, xor_d;
	logic [AddrW-1:0] rd_idx_q, rd_idx_d;

	xfp_pkg::result_t out_q, out_d;
	logic             out_vld_q;
	logic             out_load;
	logic             out_free;
	logic             in_fire;
	logic             draining;

	logic [7:0]       mem_q [xfp_pkg::PayloadMax];
	logic [7:0]       rd_data_q;
	logic             mem_we;

	logic [SizeW-1:0] cnt_nxt;
	logic [SizeW-1:0] rd_nxt;

	assign draining = (state_q == xfp_pkg::PH_RD) || (state_q == xfp_pkg::PH_OUT);
	assign out_free = !out_vld_q || m_tready;
	assign s_tready = out_free && !draining;
	assign in_fire  = s_tvalid && s_tready;
	assign cnt_nxt  = cnt_q + SizeW'(1);
	assign rd_nxt   = SizeW'(rd_idx_q) + SizeW'(1);

	always_comb begin
		state_d  = state_q;
		dir_d    = dir_q;
		size_d   = size_q;
		cnt_d    = cnt_q;
		xor_d    = xor_q;
		rd_idx_d = rd_idx_q;
		mem_we   = 1'b0;
		out_load = 1'b0;
		out_d    = '0;
		out_d.last = 1'b1;
		unique case (state_q)
			xfp_pkg::PH_M: begin
				if (in_fire) begin
					if (s_tdata != xfp_pkg::SyncM) begin
						out_load     = 1'b1;
						out_d.status = xfp_pkg::ST_BAD_HEADER;
						state_d      = xfp_pkg::PH_WAIT;
					end else begin
						state_d = xfp_pkg::PH_DIR;
					end
				end
			end
			xfp_pkg::PH_DIR: begin
				if (in_fire) begin
					dir_d   = s_tdata;
					state_d = xfp_pkg::PH_SIZE;
				end
			end
			xfp_pkg::PH_SIZE: begin
				if (in_fire) begin
					if (s_tdata > 8'(xfp_pkg::PayloadMax)) begin
						out_load     = 1'b1;
						out_d.status = xfp_pkg::ST_TOO_LARGE;
						state_d      = xfp_pkg::PH_WAIT;
					end else begin
						size_d  = s_tdata[SizeW-1:0];
						xor_d   = s_tdata;
						cnt_d   = '0;
						state_d = (s_tdata == 8'd0) ? xfp_pkg::PH_CHECK : xfp_pkg::PH_DATA;
					end
				end
			end
			xfp_pkg::PH_DATA: begin
				if (in_fire) begin
					mem_we = 1'b1;
					xor_d  = xor_q ^ s_tdata;
					cnt_d  = cnt_nxt;
					if (cnt_nxt >= size_q) begin
						state_d = xfp_pkg::PH_CHECK;
					end
				end
			end
			xfp_pkg::PH_CHECK: begin
				if (in_fire) begin
					if (s_tdata != xor_q) begin
						out_load     = 1'b1;
						out_d.status = xfp_pkg::ST_BAD_CRC;
						state_d      = xfp_pkg::PH_WAIT;
					end else if (size_q == '0) begin
						out_load        = 1'b1;
						out_d.status    = xfp_pkg::ST_OK;
						out_d.direction = dir_q;
						state_d         = xfp_pkg::PH_WAIT;
					end else begin
						rd_idx_d = '0;
						state_d  = xfp_pkg::PH_RD;
					end
				end
			end
			xfp_pkg::PH_RD: begin
				// payload RAM read issued this cycle, data lands in rd_data_q
				state_d = xfp_pkg::PH_OUT;
			end
			xfp_pkg::PH_OUT: begin
				out_d.status     = xfp_pkg::ST_OK;
				out_d.direction  = dir_q;
				out_d.frame_size = 7'(size_q);
				out_d.byte_valid = 1'b1;
				out_d.data_byte  = rd_data_q;
				out_d.byte_index = 6'(rd_idx_q);
				out_d.last       = (rd_nxt == size_q);
				if (out_free) begin
					out_load = 1'b1;
					if (rd_nxt == size_q) begin
						state_d = xfp_pkg::PH_WAIT;
					end else begin
						rd_idx_d = rd_nxt[AddrW-1:0];
						state_d  = xfp_pkg::PH_RD;
					end
				end
			end
			default: begin
				// waiting for '$'; noise is dropped
				if (in_fire) begin
					state_d = (s_tdata == xfp_pkg::SyncDollar) ? xfp_pkg::PH_M
						: xfp_pkg::PH_WAIT;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= xfp_pkg::PH_WAIT;
			dir_q     <= '0;
			size_q    <= '0;
			cnt_q     <= '0;
			xor_q     <= '0;
			rd_idx_q  <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			dir_q    <= dir_d;
			size_q   <= size_d;
			cnt_q    <= cnt_d;
			xor_q    <= xor_d;
			rd_idx_q <= rd_idx_d;
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_d;
		end
	end

	// payload RAM: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[cnt_q[AddrW-1:0]] <= s_tdata;
		end
		if (state_q == xfp_pkg::PH_RD) begin
			rd_data_q <= mem_q[rd_idx_q];
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {3'b000, out_q.byte_index, out_q.data_byte, out_q.frame_size,
		out_q.direction};
	assign m_tuser  = {out_q.byte_valid, out_q.status};
	assign m_tlast  = out_q.last;

	`XFP_ASSERT_ALWAYS(a_no_take_in_drain, draining |-> !s_tready)
	`XFP_ASSERT(a_cnt_within_size, (state_q == xfp_pkg::PH_DATA) |-> (cnt_q < size_q))
	`XFP_ASSERT(a_drain_idx_in_frame, draining |-> (SizeW'(rd_idx_q) < size_q))
	`XFP_ASSERT(a_error_is_last,
		(m_tvalid && (m_tuser[1:0] != xfp_pkg::ST_OK)) |-> (m_tlast && !m_tuser[2]))

endmodule

`default_nettype wire
